### rtl/core/ripv_pkg.sv
// Shared types and constants for the RIPv2 packet validator.
`timescale 1ns / 1ps
`default_nettype none

package ripv_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } ripv_in_t;

    typedef struct packed {
        logic        kind;
        logic        last_of_run;
        logic [4:0]  entry_index;
        logic [31:0] dest_addr;
        logic [31:0] net_mask;
        logic [31:0] next_hop;
        logic [7:0]  metric;
        logic [2:0]  status;
        logic [7:0]  command;
        logic [4:0]  entry_count;
    } ripv_out_t;

    // One queue record: an entry result, a verdict, or both from one byte.
    typedef struct packed {
        logic        has_entry;
        logic        has_verdict;
        logic [4:0]  entry_index;
        logic [31:0] dest_addr;
        logic [31:0] net_mask;
        logic [31:0] next_hop;
        logic [7:0]  metric;
        logic [2:0]  entry_status;
        logic [2:0]  verdict_status;
        logic [7:0]  command;
        logic [4:0]  entry_count;
    } ripv_rec_t;

    localparam logic [11:0] COUNT_MAX = 12'd4095;
    localparam logic [11:0] HDR_LEN   = 12'd32;
    localparam logic [11:0] CMD_POS   = 12'd28;
    localparam logic [11:0] VER_POS   = 12'd29;

    localparam logic [4:0] ENTRY_LAST = 5'd19;
    localparam logic [4:0] OFF_ADDR   = 5'd4;
    localparam logic [4:0] OFF_MASK   = 5'd8;
    localparam logic [4:0] OFF_HOP    = 5'd12;
    localparam logic [4:0] OFF_METRIC = 5'd16;

    localparam logic [7:0] CMD_REQUEST  = 8'd1;
    localparam logic [7:0] CMD_RESPONSE = 8'd2;
    localparam logic [7:0] RIP_VERSION  = 8'd2;
    localparam logic [7:0] METRIC_MIN   = 8'h01;
    localparam logic [7:0] METRIC_MAX   = 8'h10;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_BAD_LENGTH  = 3'd1;
    localparam logic [2:0] ST_TOO_MANY    = 3'd2;
    localparam logic [2:0] ST_BAD_COMMAND = 3'd3;
    localparam logic [2:0] ST_BAD_VERSION = 3'd4;
    localparam logic [2:0] ST_BAD_MASK    = 3'd5;
    localparam logic [2:0] ST_BAD_METRIC  = 3'd6;

    localparam logic KIND_ENTRY   = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

endpackage

`default_nettype wire

### rtl/core/ripv_front.sv
// Front end: byte accept, field capture, entry checks and verdict.
`timescale 1ns / 1ps
`default_nettype none

module ripv_front
    import ripv_pkg::*;
#(
    parameter int MAX_ENTRIES = 25
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      byte_valid,
    output logic           byte_stall,
    input  wire ripv_in_t  byte_beat,
    input  wire logic      q_full,
    output logic           q_push,
    output ripv_rec_t      q_rec
);

    localparam int IW = $clog2(MAX_ENTRIES + 2);
    localparam logic [IW-1:0] IDX_LIMIT = IW'(MAX_ENTRIES);
    localparam logic [IW-1:0] IDX_SAT   = IW'(MAX_ENTRIES + 1);

    logic [11:0]   count_reg, count_next;
    logic [4:0]    off_reg, off_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [31:0]   addr_reg, addr_next;
    logic [31:0]   mask_reg, mask_next;
    logic [31:0]   hop_reg, hop_next;
    logic [31:0]   metric_reg, metric_next;
    logic [7:0]    cmd_reg, cmd_next;
    logic [7:0]    ver_reg, ver_next;
    logic [2:0]    ferr_reg, ferr_next;

    logic       accept;
    logic       live;
    logic       in_entries;
    logic       take;
    logic       entry_done;
    logic       mask_ok;
    logic       metric_ok;
    logic [2:0] ent_status;
    logic [2:0] verdict_status;
    logic [7:0] b;

    assign byte_stall = q_full;
    assign accept     = byte_valid && !q_full;
    assign b          = byte_beat.data_byte;

    always_comb
    begin
        live       = count_reg != COUNT_MAX;
        in_entries = live && (count_reg >= HDR_LEN);
        take       = in_entries && (idx_reg < IDX_LIMIT);
        entry_done = take && (off_reg == ENTRY_LAST);

        count_next = live ? count_reg + 12'd1 : count_reg;
        off_next   = off_reg;
        idx_next   = idx_reg;
        if (in_entries)
        begin
            if (off_reg == ENTRY_LAST)
            begin
                off_next = 5'd0;
                idx_next = (idx_reg == IDX_SAT) ? idx_reg : idx_reg + IW'(1);
            end
            else
            begin
                off_next = off_reg + 5'd1;
            end
        end

        cmd_next = (live && count_reg == CMD_POS) ? b : cmd_reg;
        ver_next = (live && count_reg == VER_POS) ? b : ver_reg;

        addr_next   = addr_reg;
        mask_next   = mask_reg;
        hop_next    = hop_reg;
        metric_next = metric_reg;
        if (take)
        begin
            priority if (off_reg >= OFF_METRIC)
                metric_next = {metric_reg[23:0], b};
            else if (off_reg >= OFF_HOP)
                hop_next = {hop_reg[23:0], b};
            else if (off_reg >= OFF_MASK)
                mask_next = {mask_reg[23:0], b};
            else if (off_reg >= OFF_ADDR)
                addr_next = {addr_reg[23:0], b};
        end

        // ones then zeros: no set bit may sit below a clear one
        mask_ok   = ((mask_reg << 1) & ~mask_reg) == 32'd0;
        metric_ok = (metric_reg[23:0] == 24'd0) && (b >= METRIC_MIN) && (b <= METRIC_MAX);
        priority if (!mask_ok)
            ent_status = ST_BAD_MASK;
        else if (!metric_ok)
            ent_status = ST_BAD_METRIC;
        else
            ent_status = ST_OK;

        ferr_next = (entry_done && ferr_reg == ST_OK) ? ent_status : ferr_reg;

        priority if (count_next < HDR_LEN || off_next != 5'd0)
            verdict_status = ST_BAD_LENGTH;
        else if (idx_next > IDX_LIMIT)
            verdict_status = ST_TOO_MANY;
        else if (cmd_next != CMD_REQUEST && cmd_next != CMD_RESPONSE)
            verdict_status = ST_BAD_COMMAND;
        else if (ver_next != RIP_VERSION)
            verdict_status = ST_BAD_VERSION;
        else
            verdict_status = ferr_next;

        q_push = accept && (entry_done || byte_beat.last_byte);

        q_rec.has_entry      = entry_done;
        q_rec.has_verdict    = byte_beat.last_byte;
        q_rec.entry_index    = 5'(idx_reg);
        q_rec.dest_addr      = addr_reg;
        q_rec.net_mask       = mask_reg;
        q_rec.next_hop       = hop_reg;
        q_rec.metric         = b;
        q_rec.entry_status   = ent_status;
        q_rec.verdict_status = verdict_status;
        q_rec.command        = cmd_next;
        q_rec.entry_count    = (verdict_status == ST_OK) ? 5'(idx_next) : 5'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            off_reg   <= '0;
            idx_reg   <= '0;
            cmd_reg   <= '0;
            ver_reg   <= '0;
            ferr_reg  <= ST_OK;
        end
        else if (accept)
        begin
            if (byte_beat.last_byte)
            begin
                count_reg <= '0;
                off_reg   <= '0;
                idx_reg   <= '0;
                cmd_reg   <= '0;
                ver_reg   <= '0;
                ferr_reg  <= ST_OK;
            end
            else
            begin
                count_reg <= count_next;
                off_reg   <= off_next;
                idx_reg   <= idx_next;
                cmd_reg   <= cmd_next;
                ver_reg   <= ver_next;
                ferr_reg  <= ferr_next;
            end
        end
    end

    // entry words are fully refilled before use, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            addr_reg   <= addr_next;
            mask_reg   <= mask_next;
            hop_reg    <= hop_next;
            metric_reg <= metric_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/ripv_fifo.sv
// Short record queue between front end and result stage.
`timescale 1ns / 1ps
`default_nettype none

module ripv_fifo
    import ripv_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire ripv_rec_t push_rec,
    input  wire logic      pop,
    output ripv_rec_t      head,
    output logic           nonempty,
    output logic           full
);

    ripv_rec_t       slot_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg;
    logic [Q_AW-1:0] rd_ptr_reg;
    logic [Q_AW:0]   cnt_reg, cnt_next;
    logic            do_push;
    logic            do_pop;

    assign nonempty = cnt_reg != '0;
    assign full     = cnt_reg == (Q_AW+1)'(Q_DEPTH);
    assign head     = slot_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && nonempty;

    always_comb
    begin
        cnt_next = cnt_reg;
        unique case ({do_push, do_pop})
            2'b10:   cnt_next = cnt_reg + (Q_AW+1)'(1);
            2'b01:   cnt_next = cnt_reg - (Q_AW+1)'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + Q_AW'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + Q_AW'(1);
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_rec;
    end

endmodule

`default_nettype wire

### rtl/core/ripv_back.sv
// Result stage: expands queue records into output beats.
`timescale 1ns / 1ps
`default_nettype none

module ripv_back
    import ripv_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire ripv_rec_t head,
    input  wire logic      q_nonempty,
    output logic           q_pop,
    output logic           result_valid,
    input  wire logic      result_stall,
    output ripv_out_t      result_beat
);

    logic      out_valid_reg, out_valid_next;
    logic      phase_reg, phase_next;
    ripv_out_t out_reg, out_next;
    logic      can_load;
    logic      load;

    assign result_valid = out_valid_reg;
    assign result_beat  = out_reg;

    always_comb
    begin
        can_load   = !out_valid_reg || !result_stall;
        load       = can_load && q_nonempty;
        q_pop      = 1'b0;
        phase_next = phase_reg;
        out_next   = out_reg;

        if (load)
        begin
            out_next.command = head.command;
            if (head.has_entry && !phase_reg)
            begin
                out_next.kind        = KIND_ENTRY;
                out_next.last_of_run = !head.has_verdict;
                out_next.entry_index = head.entry_index;
                out_next.dest_addr   = head.dest_addr;
                out_next.net_mask    = head.net_mask;
                out_next.next_hop    = head.next_hop;
                out_next.metric      = head.metric;
                out_next.status      = head.entry_status;
                out_next.entry_count = 5'd0;
                if (head.has_verdict)
                    phase_next = 1'b1;
                else
                    q_pop = 1'b1;
            end
            else
            begin
                out_next.kind        = KIND_VERDICT;
                out_next.last_of_run = 1'b1;
                out_next.entry_index = 5'd0;
                out_next.dest_addr   = 32'd0;
                out_next.net_mask    = 32'd0;
                out_next.next_hop    = 32'd0;
                out_next.metric      = 8'd0;
                out_next.status      = head.verdict_status;
                out_next.entry_count = head.entry_count;
                q_pop      = 1'b1;
                phase_next = 1'b0;
            end
        end

        out_valid_next = load ? 1'b1 : (can_load ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_reg <= out_next;
    end

endmodule

`default_nettype wire

### rtl/core/rip_packet_validator_core.sv
// Top level of the RIPv2 packet validator.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------
//  bytes    | byte_valid / byte_stall    | byte_beat   (ripv_in_t)
//  results  | result_valid / result_stall| result_beat (ripv_out_t)
//
// One byte beat per cycle while byte_stall is low; each result passes through the queue, then the output register.
// A byte ending both an entry and the packet gives two result beats, entry
// then verdict, one after the other through the single output register.
// A four-record queue parts the front end from the result stage.
// Reset clears counters, captured header bytes and the queue.
// byte_stall rises only when the queue is full.
`timescale 1ns / 1ps
`default_nettype none

module rip_packet_validator_core
    import ripv_pkg::*;
#(
    parameter int MAX_ENTRIES = 25
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      byte_valid,
    output logic           byte_stall,
    input  wire ripv_in_t  byte_beat,
    output logic           result_valid,
    input  wire logic      result_stall,
    output ripv_out_t      result_beat
);

    logic      q_push;
    logic      q_pop;
    logic      q_full;
    logic      q_nonempty;
    ripv_rec_t q_rec;
    ripv_rec_t q_head;

    ripv_front #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_beat  (byte_beat),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_rec      (q_rec)
    );

    ripv_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_rec (q_rec),
        .pop      (q_pop),
        .head     (q_head),
        .nonempty (q_nonempty),
        .full     (q_full)
    );

    ripv_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (q_head),
        .q_nonempty   (q_nonempty),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_beat  (result_beat)
    );

endmodule

`default_nettype wire

### rtl/core/ripv_checker.sv
// Port-level assertions for the validator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module ripv_checker
    import ripv_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      byte_valid,
    input wire logic      byte_stall,
    input wire ripv_in_t  byte_beat,
    input wire logic      result_valid,
    input wire logic      result_stall,
    input wire ripv_out_t result_beat
);

    a_byte_hold: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && byte_stall |=> byte_valid && $stable(byte_beat))
        else $error("byte beat changed while stalled");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result_beat))
        else $error("result beat changed while stalled");

    a_verdict_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_beat.kind == KIND_VERDICT |->
            result_beat.last_of_run && result_beat.dest_addr == 32'd0 &&
            result_beat.entry_index == 5'd0)
        else $error("verdict beat malformed");

    a_entry_status: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_beat.kind == KIND_ENTRY |->
            result_beat.entry_count == 5'd0 &&
            (result_beat.status == ST_OK || result_beat.status == ST_BAD_MASK ||
             result_beat.status == ST_BAD_METRIC))
        else $error("entry beat has verdict-only content");

    a_count_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_beat.status != ST_OK |-> result_beat.entry_count == 5'd0)
        else $error("entry count on failed verdict");

endmodule

bind rip_packet_validator_core ripv_checker u_ripv_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_beat    (byte_beat),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_beat  (result_beat)
);

`default_nettype wire
